// File: rtl/core/gkc_pkg.sv
// Shared types and constants for the Gaussian stencil coefficient generator.
// Holds the controller state encoding, the command/status structs and the fixed-point constants.
// No dependencies.
package gkc_pkg;

  localparam int MAX_SIZE_DEF  = 16;
  localparam int COEF_BITS_DEF = 16;

  localparam int KS_W       = 5;
  localparam int SIG_W      = 16;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [KS_W-1:0]  KS_RESET  = 5'd9;
  localparam logic [SIG_W-1:0] SIG_RESET = 16'd307;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SQ    = 1'b1;

  // exponent t in Q.32, always below 32.0
  localparam int T_W     = 37;
  localparam int T_SHIFT = 39;
  localparam int N_W     = 6;
  localparam int R_W     = 32;
  localparam int SUM_W   = 33;
  localparam int RK_W    = 3;
  localparam int K_W     = 4;

  localparam logic [R_W-1:0]   LN2_Q32      = 32'd2977044472;
  localparam logic [RK_W-1:0]  RED_TOP      = 3'd5;
  localparam logic [K_W-1:0]   TAYLOR_TERMS = 4'd12;
  localparam logic [SUM_W-1:0] ONE_Q32      = 33'h1_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ERR,
    ST_W_START,
    ST_T_DIV,
    ST_RED,
    ST_MUL,
    ST_K_START,
    ST_K_DIV,
    ST_WSHIFT,
    ST_W_DONE,
    ST_FIN_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic init_sum;
    logic init_row;
    logic sel_row;
    logic set_w_zero;
    logic start_t_div;
    logic cap_t;
    logic red_step;
    logic series_init;
    logic mul;
    logic start_k_div;
    logic acc;
    logic wshift;
    logic add_acc;
    logic adv_ij;
    logic adv_j;
    logic start_fin;
    logic cap_coef;
    logic out_load;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic row_bad;
    logic w_zero;
    logic div_done;
    logic red_last;
    logic k_last;
    logic ij_last;
    logic j_last;
  } status_t;

endpackage

// File: rtl/core/gkc_if.sv
// Valid/ready channel interfaces for row requests and coefficient beats.
// Depends on gkc_pkg for field widths.
interface gkc_in_if;
  logic                      valid;
  logic                      ready;
  logic [gkc_pkg::ROW_W-1:0] row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

interface gkc_out_if #(
  parameter int COEF_BITS = gkc_pkg::COEF_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic [COEF_BITS-1:0]      coefficient;
  logic [gkc_pkg::COL_W-1:0] column_index;
  logic                      last;
  logic                      row_error;

  modport source (output valid, output coefficient, output column_index,
                  output last, output row_error, input ready);
  modport sink   (input valid, input coefficient, input column_index,
                  input last, input row_error, output ready);
endinterface

// File: rtl/core/gkc_div.sv
// Shared restoring divider: one quotient bit per cycle, numerator left-aligned.
// Depends on nothing but its parameters.
module gkc_div #(
  parameter int NUMW = 56,
  parameter int DENW = 40,
  parameter int CNTW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  input  logic [CNTW-1:0] steps,
  output logic            done,
  output logic [NUMW-1:0] quot
);

  logic [NUMW-1:0] num_r, num_nxt;
  logic [DENW-1:0] den_r, den_nxt;
  logic [DENW-1:0] rem_r, rem_nxt;
  logic [NUMW-1:0] quot_r, quot_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DENW:0]   rem_sh;
  logic            ge;

  assign rem_sh = {rem_r, num_r[NUMW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = steps;
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[NUMW-2:0], 1'b0};
      rem_nxt  = ge ? DENW'(rem_sh - {1'b0, den_r}) : DENW'(rem_sh);
      quot_nxt = {quot_r[NUMW-2:0], ge};
      cnt_nxt  = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = (cnt_r == '0);
  assign quot = quot_r;

endmodule

// File: rtl/core/gkc_dp.sv
// Datapath: grid geometry, exponent, range reduction, Taylor series, grid sum and
// normalisation, plus the result payload register. Depends on gkc_pkg and gkc_div.
module gkc_dp #(
  parameter int MAX_SIZE  = gkc_pkg::MAX_SIZE_DEF,
  parameter int COEF_BITS = gkc_pkg::COEF_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gkc_pkg::cmd_t               cmd,
  input  logic [gkc_pkg::KS_W-1:0]    ks,
  input  logic [gkc_pkg::SIG_W-1:0]   sig,
  input  logic [gkc_pkg::ROW_W-1:0]   in_row,
  output gkc_pkg::status_t            status,
  output logic [COEF_BITS-1:0]        coef,
  output logic [gkc_pkg::COL_W-1:0]   col,
  output logic                        last,
  output logic                        err
);

  localparam int DW    = $clog2(MAX_SIZE);
  localparam int NSW   = $clog2(MAX_SIZE + 1);
  localparam int DQW   = 2 * DW + 1;
  localparam int DENSW = gkc_pkg::SIG_W + 2 * DW;
  localparam int WW    = 32 + 2 * DW;
  localparam int FINW  = ((32 + COEF_BITS) > (31 + 2 * DW) ? (32 + COEF_BITS) : (31 + 2 * DW)) + 1;
  localparam int TNW   = DQW + gkc_pkg::T_SHIFT;
  localparam int NUMW  = (TNW > FINW) ? TNW : FINW;
  localparam int DENW  = WW;
  localparam int CNTW  = $clog2(NUMW + 1);

  // effective geometry
  logic [NSW-1:0]           n_eff;
  logic [DW-1:0]            d;
  logic [gkc_pkg::SIG_W-1:0] sig_eff;

  always_comb begin
    if (ks < gkc_pkg::KS_W'(2)) begin
      n_eff = NSW'(2);
    end else if (ks > MAX_SIZE) begin
      n_eff = NSW'(MAX_SIZE);
    end else begin
      n_eff = NSW'(ks);
    end
  end

  assign d       = DW'(n_eff - NSW'(1));
  assign sig_eff = (sig == '0) ? gkc_pkg::SIG_W'(1) : sig;

  logic [gkc_pkg::ROW_W-1:0] row_r;
  logic [2*DW-1:0]           d2_r;
  logic [DENSW-1:0]          den_r;
  logic [DW-1:0]             i_r, j_r;
  logic [31:0]               w_r;
  logic [gkc_pkg::T_W-1:0]   t_r;
  logic [gkc_pkg::N_W-1:0]   n_r;
  logic [gkc_pkg::RK_W-1:0]  rk_r;
  logic [31:0]               term_r;
  logic [gkc_pkg::SUM_W-1:0] sum_r;
  logic [gkc_pkg::K_W-1:0]   k_r;
  logic [31:0]               prod_r;
  logic [WW-1:0]             acc_r;
  logic [COEF_BITS-1:0]      coef_r;
  logic [COEF_BITS-1:0]      out_coef_r;
  logic [gkc_pkg::COL_W-1:0] out_col_r;
  logic                      out_last_r, out_err_r;

  // grid excess q - qmin for the current point
  logic [DW-1:0] gi;
  logic [DW:0]   gi2, gj2, dx, ai, aj;
  logic [2*DW-1:0] sqi, sqj;
  logic [DQW-1:0]  q, dq;

  assign gi  = cmd.sel_row ? DW'(row_r) : i_r;
  assign gi2 = {gi, 1'b0};
  assign gj2 = {j_r, 1'b0};
  assign dx  = {1'b0, d};
  assign ai  = (gi2 >= dx) ? (gi2 - dx) : (dx - gi2);
  assign aj  = (gj2 >= dx) ? (gj2 - dx) : (dx - gj2);
  assign sqi = (2*DW)'(ai[DW-1:0]) * (2*DW)'(ai[DW-1:0]);
  assign sqj = (2*DW)'(aj[DW-1:0]) * (2*DW)'(aj[DW-1:0]);
  assign q   = DQW'(sqi) + DQW'(sqj);
  assign dq  = q - (d[0] ? DQW'(2) : DQW'(0));

  // divider operand selection
  logic            div_start, div_done;
  logic [NUMW-1:0] div_num, div_quot;
  logic [DENW-1:0] div_den;
  logic [CNTW-1:0] div_steps;
  logic [FINW-1:0] fin_num;

  assign div_start = cmd.start_t_div | cmd.start_k_div | cmd.start_fin;
  assign fin_num   = (FINW'(w_r) << COEF_BITS) + FINW'(acc_r >> 1);

  always_comb begin
    if (cmd.start_t_div) begin
      div_num   = NUMW'({dq, {gkc_pkg::T_SHIFT{1'b0}}}) << (NUMW - TNW);
      div_den   = DENW'(den_r);
      div_steps = CNTW'(TNW);
    end else if (cmd.start_k_div) begin
      div_num   = NUMW'(prod_r) << (NUMW - 32);
      div_den   = DENW'(k_r);
      div_steps = CNTW'(32);
    end else begin
      div_num   = NUMW'(fin_num) << (NUMW - FINW);
      div_den   = acc_r;
      div_steps = CNTW'(FINW);
    end
  end

  gkc_div #(
    .NUMW(NUMW),
    .DENW(DENW),
    .CNTW(CNTW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .steps(div_steps),
    .done (div_done),
    .quot (div_quot)
  );

  logic [gkc_pkg::T_W-1:0] red_cmp;
  logic [63:0]             mprod;
  logic [31:0]             r;

  assign red_cmp = gkc_pkg::T_W'(gkc_pkg::LN2_Q32) << rk_r;
  assign r       = t_r[31:0];
  assign mprod   = {32'b0, term_r} * {32'b0, r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_row;
      d2_r  <= (2*DW)'(d) * (2*DW)'(d);
    end
    if (cmd.setup) begin
      den_r <= DENSW'(sig_eff) * DENSW'(d2_r);
    end
    if (cmd.init_sum) begin
      i_r   <= '0;
      j_r   <= '0;
      acc_r <= '0;
    end else if (cmd.init_row) begin
      j_r <= '0;
    end else if (cmd.adv_ij) begin
      if (j_r == d) begin
        j_r <= '0;
        i_r <= i_r + DW'(1);
      end else begin
        j_r <= j_r + DW'(1);
      end
    end else if (cmd.adv_j) begin
      j_r <= j_r + DW'(1);
    end
    if (cmd.add_acc) begin
      acc_r <= acc_r + WW'(w_r);
    end
    if (cmd.set_w_zero) begin
      w_r <= '0;
    end else if (cmd.wshift) begin
      w_r <= 32'(sum_r >> ({1'b0, n_r} + 7'd1));
    end
    if (cmd.cap_t) begin
      t_r  <= div_quot[gkc_pkg::T_W-1:0];
      n_r  <= '0;
      rk_r <= gkc_pkg::RED_TOP;
    end else if (cmd.red_step) begin
      if (t_r >= red_cmp) begin
        t_r       <= t_r - red_cmp;
        n_r[rk_r] <= 1'b1;
      end
      rk_r <= rk_r - gkc_pkg::RK_W'(1);
    end
    if (cmd.series_init) begin
      sum_r <= gkc_pkg::ONE_Q32;
      k_r   <= gkc_pkg::K_W'(1);
    end else if (cmd.acc) begin
      term_r <= div_quot[31:0];
      sum_r  <= k_r[0] ? (sum_r - gkc_pkg::SUM_W'(div_quot[31:0]))
                       : (sum_r + gkc_pkg::SUM_W'(div_quot[31:0]));
      k_r    <= k_r + gkc_pkg::K_W'(1);
    end
    if (cmd.mul) begin
      // first term of the series is exactly 1.0, so its product is r itself
      prod_r <= (k_r == gkc_pkg::K_W'(1)) ? r : mprod[63:32];
    end
    if (cmd.cap_coef) begin
      coef_r <= (|div_quot[NUMW-1:COEF_BITS]) ? '1 : div_quot[COEF_BITS-1:0];
    end
    if (cmd.out_load) begin
      out_coef_r <= coef_r;
      out_col_r  <= gkc_pkg::COL_W'(j_r);
      out_last_r <= (j_r == d);
      out_err_r  <= 1'b0;
    end else if (cmd.out_err) begin
      out_coef_r <= '0;
      out_col_r  <= '0;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign status.row_bad  = (row_r >= n_eff);
  assign status.w_zero   = ({dq, 2'b00} >= den_r);
  assign status.div_done = div_done;
  assign status.red_last = (rk_r == '0);
  assign status.k_last   = (k_r == gkc_pkg::TAYLOR_TERMS);
  assign status.ij_last  = (i_r == d) && (j_r == d);
  assign status.j_last   = (j_r == d);

  assign coef = out_coef_r;
  assign col  = out_col_r;
  assign last = out_last_r;
  assign err  = out_err_r;

endmodule

// File: rtl/core/gkc_ctrl.sv
// Controller: sequences grid sum, per-weight exponential and row normalisation.
// Depends on gkc_pkg; drives the datapath through cmd_t and reads status_t.
module gkc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_ready,
  input  logic             cfg_we,
  input  gkc_pkg::status_t status,
  output logic             in_ready,
  output logic             out_valid,
  output gkc_pkg::cmd_t    cmd
);

  gkc_pkg::state_t state_r, state_nxt;
  logic sum_valid_r, sum_valid_nxt;
  logic row_phase_r, row_phase_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gkc_pkg::ST_IDLE:    if (in_valid) state_nxt = gkc_pkg::ST_SETUP;
      gkc_pkg::ST_SETUP: begin
        state_nxt = status.row_bad ? gkc_pkg::ST_ERR : gkc_pkg::ST_W_START;
      end
      gkc_pkg::ST_ERR:     if (out_free) state_nxt = gkc_pkg::ST_IDLE;
      gkc_pkg::ST_W_START: begin
        state_nxt = status.w_zero ? gkc_pkg::ST_W_DONE : gkc_pkg::ST_T_DIV;
      end
      gkc_pkg::ST_T_DIV:   if (status.div_done) state_nxt = gkc_pkg::ST_RED;
      gkc_pkg::ST_RED:     if (status.red_last) state_nxt = gkc_pkg::ST_MUL;
      gkc_pkg::ST_MUL:     state_nxt = gkc_pkg::ST_K_START;
      gkc_pkg::ST_K_START: state_nxt = gkc_pkg::ST_K_DIV;
      gkc_pkg::ST_K_DIV: begin
        if (status.div_done) begin
          state_nxt = status.k_last ? gkc_pkg::ST_WSHIFT : gkc_pkg::ST_MUL;
        end
      end
      gkc_pkg::ST_WSHIFT:  state_nxt = gkc_pkg::ST_W_DONE;
      gkc_pkg::ST_W_DONE: begin
        state_nxt = row_phase_r ? gkc_pkg::ST_FIN_DIV : gkc_pkg::ST_W_START;
      end
      gkc_pkg::ST_FIN_DIV: if (status.div_done) state_nxt = gkc_pkg::ST_OUT;
      gkc_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = status.j_last ? gkc_pkg::ST_IDLE : gkc_pkg::ST_W_START;
        end
      end
      default:             state_nxt = gkc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.sel_row   = row_phase_r;
    in_ready      = 1'b0;
    sum_valid_nxt = sum_valid_r;
    row_phase_nxt = row_phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      gkc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gkc_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        if (!status.row_bad) begin
          if (sum_valid_r) begin
            cmd.init_row  = 1'b1;
            row_phase_nxt = 1'b1;
          end else begin
            cmd.init_sum  = 1'b1;
            row_phase_nxt = 1'b0;
          end
        end
      end
      gkc_pkg::ST_ERR: begin
        if (out_free) begin
          cmd.out_err   = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      gkc_pkg::ST_W_START: begin
        cmd.set_w_zero  = status.w_zero;
        cmd.start_t_div = !status.w_zero;
      end
      gkc_pkg::ST_T_DIV:   cmd.cap_t = status.div_done;
      gkc_pkg::ST_RED: begin
        cmd.red_step    = 1'b1;
        cmd.series_init = status.red_last;
      end
      gkc_pkg::ST_MUL:     cmd.mul = 1'b1;
      gkc_pkg::ST_K_START: cmd.start_k_div = 1'b1;
      gkc_pkg::ST_K_DIV:   cmd.acc = status.div_done;
      gkc_pkg::ST_WSHIFT:  cmd.wshift = 1'b1;
      gkc_pkg::ST_W_DONE: begin
        if (row_phase_r) begin
          cmd.start_fin = 1'b1;
        end else begin
          cmd.add_acc = 1'b1;
          if (status.ij_last) begin
            // grid sum complete: hold it until the next configuration write
            sum_valid_nxt = 1'b1;
            row_phase_nxt = 1'b1;
            cmd.init_row  = 1'b1;
          end else begin
            cmd.adv_ij = 1'b1;
          end
        end
      end
      gkc_pkg::ST_FIN_DIV: cmd.cap_coef = status.div_done;
      gkc_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.adv_j     = !status.j_last;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (cfg_we) begin
      sum_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gkc_pkg::ST_IDLE;
      sum_valid_r <= 1'b0;
      row_phase_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_valid_r <= sum_valid_nxt;
      row_phase_r <= row_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/gaussian_kernel_coefficients_top.sv
// Top level: configuration registers, controller and datapath of the stencil generator.
// Depends on gkc_pkg, gkc_if, gkc_ctrl, gkc_dp (and gkc_div below it).
// Each nonzero weight runs an exponent divide, a range reduction and a Taylor loop, all
// on the shared bit-serial divider. Each row computes N weights and N normalising divides;
// the first in-range row after reset or a configuration write also computes the N*N
// weights of the grid sum. One request at a time.
// Reset: kernel_size 9, sigma_sq 307, grid sum cache empty, no beat pending.
module gaussian_kernel_coefficients_top #(
  parameter int MAX_SIZE  = gkc_pkg::MAX_SIZE_DEF,
  parameter int COEF_BITS = gkc_pkg::COEF_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gkc_in_if.sink                          in_ch,
  gkc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gkc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gkc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [gkc_pkg::KS_W-1:0]  ks_r;
  logic [gkc_pkg::SIG_W-1:0] sig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r  <= gkc_pkg::KS_RESET;
      sig_r <= gkc_pkg::SIG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gkc_pkg::REG_KERNEL_SIZE: ks_r  <= cfg_data[gkc_pkg::KS_W-1:0];
        gkc_pkg::REG_SIGMA_SQ:    sig_r <= cfg_data[gkc_pkg::SIG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gkc_pkg::cmd_t    cmd;
  gkc_pkg::status_t status;

  gkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_ready(out_ch.ready),
    .cfg_we   (cfg_we),
    .status   (status),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .cmd      (cmd)
  );

  gkc_dp #(
    .MAX_SIZE (MAX_SIZE),
    .COEF_BITS(COEF_BITS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .ks    (ks_r),
    .sig   (sig_r),
    .in_row(in_ch.row_index),
    .status(status),
    .coef  (out_ch.coefficient),
    .col   (out_ch.column_index),
    .last  (out_ch.last),
    .err   (out_ch.row_error)
  );

  // an error beat always closes its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.row_error |-> out_ch.last && (out_ch.coefficient == '0))
    else $error("row error beat without last or with nonzero coefficient");

  // one request in flight: no new beat taken right after one is accepted
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while busy");

  // a new result beat only appears while the block is not idle-accepting
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready && in_ch.valid))
    else $error("result beat raised directly from request acceptance");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Gaussian stencil coefficient generator.
// Drives row requests, predicts each coefficient beat in fixed point, checks every beat.
// Depends on gkc_pkg, gkc_if and gaussian_kernel_coefficients_top.
module tb_top;

  localparam int IDLE_LIMIT = 400000;
  localparam int SETTLE     = 40;

  typedef struct {
    logic [15:0]               coefficient;
    logic [gkc_pkg::COL_W-1:0] column_index;
    logic                      last;
    logic                      row_error;
  } beat_t;

  class coef_scoreboard;
    logic [gkc_pkg::KS_W-1:0]  ksize;
    logic [gkc_pkg::SIG_W-1:0] sig;
    beat_t                     pending_beats[$];
    int                        errors;

    function new();
      ksize  = gkc_pkg::KS_RESET;
      sig    = gkc_pkg::SIG_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [gkc_pkg::CFG_IDX_W-1:0] idx,
                          logic [gkc_pkg::CFG_DATA_W-1:0] data);
      if (idx == gkc_pkg::REG_KERNEL_SIZE) ksize = data[gkc_pkg::KS_W-1:0];
      else sig = data;
    endfunction

    function int unsigned side();
      if (ksize < 2) return 2;
      if (ksize > 16) return 16;
      return ksize;
    endfunction

    // append one predicted beat
    function void queue_beat(beat_t b);
      pending_beats = {pending_beats, b};
    endfunction

    // weight in Q0.31 for grid excess dq
    function longint unsigned gauss(longint unsigned dq, longint unsigned den);
      longint unsigned t, r, term, acc, nsh;
      if (dq * 4 >= den) return 0;
      t    = ((dq * 128) << 32) / den;
      nsh  = t / gkc_pkg::LN2_Q32;
      r    = t - nsh * gkc_pkg::LN2_Q32;
      term = 64'd1 << 32;
      acc  = term;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * r) >> 32) / k;
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      return acc >> (nsh + 1);
    endfunction

    function longint unsigned grid_weight(int i, int j, int d, longint unsigned den);
      longint signed ai, aj;
      longint unsigned qmin;
      ai   = 2 * i - d;
      aj   = 2 * j - d;
      qmin = 2 * (d % 2);
      return gauss(longint'(ai * ai + aj * aj) - qmin, den);
    endfunction

    function void note_row(logic [gkc_pkg::ROW_W-1:0] row);
      int unsigned n, d;
      longint unsigned den, total, w, c;
      beat_t b;
      n   = side();
      d   = n - 1;
      den = ((sig == 0) ? 1 : sig) * d * d;
      if (row >= n) begin
        b = '{16'd0, '0, 1'b1, 1'b1};
        queue_beat(b);
        return;
      end
      total = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) total += grid_weight(i, j, d, den);
      for (int j = 0; j < n; j++) begin
        w = grid_weight(row, j, d, den);
        c = ((w << 16) + (total >> 1)) / total;
        if (c > 65535) c = 65535;
        b.coefficient  = c[15:0];
        b.column_index = j[gkc_pkg::COL_W-1:0];
        b.last         = (j + 1 == n);
        b.row_error    = 1'b0;
        queue_beat(b);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t e;
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: coefficient %0d column %0d", got.coefficient,
               got.column_index);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      if (got.coefficient !== e.coefficient) begin
        $error("coefficient: expected %0d, got %0d", e.coefficient, got.coefficient);
        errors++;
      end
      if (got.column_index !== e.column_index) begin
        $error("column_index: expected %0d, got %0d", e.column_index, got.column_index);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, got.last);
        errors++;
      end
      if (got.row_error !== e.row_error) begin
        $error("row_error: expected %0b, got %0b", e.row_error, got.row_error);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [gkc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gkc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           quiet;
  int                             idle_cycles;
  coef_scoreboard                 sb;

  gkc_in_if  in_ch();
  gkc_out_if out_ch();

  gaussian_kernel_coefficients_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: ready in random bursts, held high when quiet
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.coefficient  = out_ch.coefficient;
      got.column_index = out_ch.column_index;
      got.last         = out_ch.last;
      got.row_error    = out_ch.row_error;
      sb.check_beat(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_row(logic [gkc_pkg::ROW_W-1:0] row);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.row_index <= row;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_row(row);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [gkc_pkg::CFG_IDX_W-1:0] idx,
                           logic [gkc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  function automatic logic [gkc_pkg::ROW_W-1:0] pick_row();
    if ($urandom_range(0, 9) < 7)
      return gkc_pkg::ROW_W'($urandom_range(0, sb.side() - 1));
    return gkc_pkg::ROW_W'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [gkc_pkg::KS_W-1:0]  ks;
    logic [gkc_pkg::SIG_W-1:0] sg;
    int                        count;
    sb              = new();
    quiet           = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.row_index = '0;
    idle_cycles     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, edge rows and bad rows
    send_row(4'd0);
    send_row(4'd4);
    send_row(4'd8);
    send_row(4'd9);
    send_row(4'd15);
    drain();
    // Smallest stencil with zero variance, then widest variance
    write_reg(gkc_pkg::REG_KERNEL_SIZE, 16'd2);
    write_reg(gkc_pkg::REG_SIGMA_SQ, 16'd0);
    send_row(4'd0);
    send_row(4'd1);
    send_row(4'd2);
    drain();
    write_reg(gkc_pkg::REG_SIGMA_SQ, 16'hFFFF);
    send_row(4'd1);
    send_row(4'd0);
    drain();
    // Clamped sizes below and above the range
    write_reg(gkc_pkg::REG_KERNEL_SIZE, 16'd1);
    write_reg(gkc_pkg::REG_SIGMA_SQ, 16'd1);
    send_row(4'd1);
    send_row(4'd3);
    drain();
    write_reg(gkc_pkg::REG_KERNEL_SIZE, 16'd31);
    write_reg(gkc_pkg::REG_SIGMA_SQ, 16'd64);
    send_row(4'd15);
    send_row(4'd7);
    drain();
    write_reg(gkc_pkg::REG_KERNEL_SIZE, 16'd0);
    send_row(4'd1);
    send_row(4'd2);

    // Random phases, mostly small stencils; full size only three times
    for (int p = 0; p < 20; p++) begin
      drain();
      quiet = (p >= 17);
      if (p == 6 || p == 13) ks = 5'd16;
      else if (p == 3) ks = 5'd17;
      else ks = 5'($urandom_range(2, 5));
      case ($urandom_range(0, 4))
        0:       sg = 16'($urandom_range(1, 65535));
        1:       sg = (p % 2) ? 16'hFFFF : 16'd1;
        default: sg = 16'($urandom_range(1, 1200));
      endcase
      write_reg(gkc_pkg::REG_KERNEL_SIZE, {11'd0, ks});
      write_reg(gkc_pkg::REG_SIGMA_SQ, sg);
      count = (ks == 5'd16) ? 3 : 17;
      for (int k = 0; k < count; k++) begin
        // hold the sender until the block has emptied once
        if (p == 9 && k == 8) begin
          in_ch.valid <= 1'b0;
          while (sb.pending_beats.size() != 0) @(posedge clk);
          @(negedge clk);
        end
        send_row(pick_row());
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
